// ===== rtl/core/kct_pkg.sv =====
// Shared types, codes and the seven-segment table of the keypad countdown timer.
`default_nettype none

package kct_pkg;

  // Command codes of one input item.
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Key codes: the highest digit key and the star key that starts the countdown.
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;

  // BCD limits, the alarm length after reset and the shortest alarm length.
  localparam logic [3:0] BCD_ZERO        = 4'd0;
  localparam logic [3:0] BCD_NINE        = 4'd9;
  localparam logic [7:0] ALARM_LEN_RESET = 8'd2;
  localparam logic [7:0] ALARM_LEN_MIN   = 8'd1;

  // One result item as it leaves the timer core.
  typedef struct packed {
    logic [3:0] ones_digit;
    logic [3:0] tens_digit;
    logic [6:0] ones_segments;
    logic [6:0] tens_segments;
    logic       buzzer_on;
    logic       counting;
    logic       entry_active;
  } kct_result_t;

  // Seven-segment pattern, bit 0 is segment a, active high; non-digits are blank.
  function automatic logic [6:0] seg7(input logic [3:0] digit);
    logic [6:0] pattern;
    unique case (digit)
      4'd0:    pattern = 7'h3F;
      4'd1:    pattern = 7'h06;
      4'd2:    pattern = 7'h5B;
      4'd3:    pattern = 7'h4F;
      4'd4:    pattern = 7'h66;
      4'd5:    pattern = 7'h6D;
      4'd6:    pattern = 7'h7D;
      4'd7:    pattern = 7'h07;
      4'd8:    pattern = 7'h7F;
      4'd9:    pattern = 7'h6F;
      default: pattern = 7'h00;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kct_channels.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface kct_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] key_code;

  modport source (output valid, output command, output key_code, input ready);
  modport sink   (input valid, input command, input key_code, output ready);
endinterface

interface kct_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] ones_digit;
  logic [3:0] tens_digit;
  logic [6:0] ones_segments;
  logic [6:0] tens_segments;
  logic       buzzer_on;
  logic       counting;
  logic       entry_active;

  modport source (
    output valid, output ones_digit, output tens_digit, output ones_segments,
    output tens_segments, output buzzer_on, output counting, output entry_active,
    input ready
  );
  modport sink (
    input valid, input ones_digit, input tens_digit, input ones_segments,
    input tens_segments, input buzzer_on, input counting, input entry_active,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/kct_engine.sv =====
// Timer state, next-state logic and the result that follows each accepted item.
`default_nettype none

module kct_engine
  import kct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [7:0]  cfg_write_data,
  input  wire logic        item_accept,
  input  wire logic        command,
  input  wire logic [3:0]  key_code,
  output kct_result_t      result_next
);

  logic [7:0] alarm_length;
  logic [3:0] entered_tens, entered_tens_next;
  logic [3:0] entered_units, entered_units_next;
  logic       have_digit, have_digit_next;
  logic       running, running_next;
  logic [3:0] rem_tens, rem_tens_next;
  logic [3:0] rem_ones, rem_ones_next;
  logic       alarm_active, alarm_active_next;
  logic [7:0] alarm_ticks_left, alarm_ticks_left_next;

  logic       entry_mode;
  logic [3:0] dec_ones, dec_tens;
  logic [7:0] alarm_start_ticks;
  logic [7:0] ticks_dec;
  logic [3:0] show_ones, show_tens;

  assign entry_mode        = !running && !alarm_active;
  assign alarm_start_ticks = (alarm_length == 8'd0) ? ALARM_LEN_MIN : alarm_length;

  // Remaining seconds are held as two BCD digits; one tick is a BCD decrement.
  always_comb begin
    if (rem_ones == BCD_ZERO) begin
      dec_ones = BCD_NINE;
      dec_tens = rem_tens - 4'd1;
    end else begin
      dec_ones = rem_ones - 4'd1;
      dec_tens = rem_tens;
    end
    ticks_dec = (alarm_ticks_left != 8'd0) ? alarm_ticks_left - 8'd1 : alarm_ticks_left;
  end

  // Next state for the item being transferred.
  always_comb begin
    entered_tens_next     = entered_tens;
    entered_units_next    = entered_units;
    have_digit_next       = have_digit;
    running_next          = running;
    rem_tens_next         = rem_tens;
    rem_ones_next         = rem_ones;
    alarm_active_next     = alarm_active;
    alarm_ticks_left_next = alarm_ticks_left;

    if (command == CMD_KEY) begin
      if (entry_mode) begin
        if (key_code <= KEY_DIGIT_MAX) begin
          entered_units_next = key_code;
          entered_tens_next  = have_digit ? entered_units : BCD_ZERO;
          have_digit_next    = 1'b1;
        end else if (key_code == KEY_STAR && have_digit) begin
          if (entered_tens == BCD_ZERO && entered_units == BCD_ZERO) begin
            // A start at 00 goes straight to the alarm.
            running_next          = 1'b0;
            rem_tens_next         = BCD_ZERO;
            rem_ones_next         = BCD_ZERO;
            alarm_active_next     = 1'b1;
            alarm_ticks_left_next = alarm_start_ticks;
          end else begin
            rem_tens_next = entered_tens;
            rem_ones_next = entered_units;
            running_next  = 1'b1;
          end
        end
      end
    end else if (running) begin
      rem_tens_next = dec_tens;
      rem_ones_next = dec_ones;
      if (dec_tens == BCD_ZERO && dec_ones == BCD_ZERO) begin
        running_next          = 1'b0;
        alarm_active_next     = 1'b1;
        alarm_ticks_left_next = alarm_start_ticks;
      end
    end else if (alarm_active) begin
      alarm_ticks_left_next = ticks_dec;
      if (ticks_dec == 8'd0) begin
        alarm_active_next  = 1'b0;
        entered_tens_next  = BCD_ZERO;
        entered_units_next = BCD_ZERO;
        have_digit_next    = 1'b0;
      end
    end
  end

  // The result shows the state after the update.
  always_comb begin
    if (running_next || alarm_active_next) begin
      show_ones = rem_ones_next;
      show_tens = rem_tens_next;
    end else begin
      show_ones = entered_units_next;
      show_tens = entered_tens_next;
    end
    result_next.ones_digit    = show_ones;
    result_next.tens_digit    = show_tens;
    result_next.ones_segments = seg7(show_ones);
    result_next.tens_segments = seg7(show_tens);
    result_next.buzzer_on     = alarm_active_next;
    result_next.counting      = running_next;
    result_next.entry_active  = !running_next && !alarm_active_next;
  end

  // State registers and the alarm length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_length     <= ALARM_LEN_RESET;
      entered_tens     <= BCD_ZERO;
      entered_units    <= BCD_ZERO;
      have_digit       <= 1'b0;
      running          <= 1'b0;
      rem_tens         <= BCD_ZERO;
      rem_ones         <= BCD_ZERO;
      alarm_active     <= 1'b0;
      alarm_ticks_left <= 8'd0;
    end else begin
      if (cfg_write_en) begin
        alarm_length <= cfg_write_data;
      end
      if (item_accept) begin
        entered_tens     <= entered_tens_next;
        entered_units    <= entered_units_next;
        have_digit       <= have_digit_next;
        running          <= running_next;
        rem_tens         <= rem_tens_next;
        rem_ones         <= rem_ones_next;
        alarm_active     <= alarm_active_next;
        alarm_ticks_left <= alarm_ticks_left_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/keypad_countdown_timer.sv =====
// Two-digit keypad countdown timer: top level with the result register.
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one item per cycle; the input is ready whenever the result
// register is empty or its result is taken in the same cycle.
// Reset (synchronous, active high) clears the timer to entry mode with 00,
// empties the result register and sets the alarm length to two ticks.
`default_nettype none

module keypad_countdown_timer
  import kct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  kct_in_if.sink          in_ch,
  kct_out_if.source       out_ch
);

  logic        in_transfer;
  logic        out_valid;
  kct_result_t result_next;
  kct_result_t result;

  // The input is taken whenever the result register can be refilled.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_transfer = in_ch.valid && in_ch.ready;

  kct_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_accept    (in_transfer),
    .command        (in_ch.command),
    .key_code       (in_ch.key_code),
    .result_next    (result_next)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_transfer) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (in_transfer) begin
      result <= result_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.ones_digit    = result.ones_digit;
  assign out_ch.tens_digit    = result.tens_digit;
  assign out_ch.ones_segments = result.ones_segments;
  assign out_ch.tens_segments = result.tens_segments;
  assign out_ch.buzzer_on     = result.buzzer_on;
  assign out_ch.counting      = result.counting;
  assign out_ch.entry_active  = result.entry_active;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench of the keypad countdown timer, with its own display predictor.
`timescale 1ns / 1ps

module tb
  import kct_pkg::*;
;

  // Key codes the block ignores in entry mode.
  localparam logic [3:0] KEY_HASH     = 4'd11;
  localparam logic [3:0] KEY_LETTER_A = 4'd12;
  localparam logic [3:0] KEY_LETTER_D = 4'd15;

  // Largest alarm length of the configuration register.
  localparam logic [7:0] ALARM_LEN_MAX = 8'd255;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SHOWN_ERRORS  = 10;
  localparam int SETTLE_CYCLES = 4;

  logic       clk;
  logic       rst;
  logic       cfg_write_en;
  logic [7:0] cfg_write_data;

  kct_in_if  in_ch ();
  kct_out_if out_ch ();

  keypad_countdown_timer DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch)
  );

  // Predicted timer state and alarm length.
  logic [3:0] pend_tens;
  logic [3:0] pend_units;
  logic       digit_seen;
  logic       cd_running;
  logic [6:0] secs_left;
  logic       buzzing;
  logic [7:0] buzz_left;
  logic [7:0] buzz_len;

  kct_result_t display_expect_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int stall_hold;
  int items_sent;
  int displays_checked;
  int error_count;
  int countdowns_started;
  int alarms_done;
  int cycle_count;

  // Seven-segment coding of one decimal digit, bit 0 is segment a.
  function automatic logic [6:0] digit_pattern(input logic [3:0] digit);
    logic [6:0] segs;
    case (digit)
      4'd0:    segs = 7'b0111111;
      4'd1:    segs = 7'b0000110;
      4'd2:    segs = 7'b1011011;
      4'd3:    segs = 7'b1001111;
      4'd4:    segs = 7'b1100110;
      4'd5:    segs = 7'b1101101;
      4'd6:    segs = 7'b1111101;
      4'd7:    segs = 7'b0000111;
      4'd8:    segs = 7'b1111111;
      4'd9:    segs = 7'b1101111;
      default: segs = 7'b0000000;
    endcase
    return segs;
  endfunction

  function automatic void predict_reset();
    pend_tens  = BCD_ZERO;
    pend_units = BCD_ZERO;
    digit_seen = 1'b0;
    cd_running = 1'b0;
    secs_left  = '0;
    buzzing    = 1'b0;
    buzz_left  = '0;
    buzz_len   = ALARM_LEN_RESET;
  endfunction

  // The countdown stops and the buzzer starts; a length of zero counts as one tick.
  function automatic void start_buzzer();
    cd_running = 1'b0;
    secs_left  = '0;
    buzzing    = 1'b1;
    buzz_left  = (buzz_len == 8'd0) ? ALARM_LEN_MIN : buzz_len;
  endfunction

  // Applies one key or tick to the predicted state and returns the display after it.
  function automatic kct_result_t timer_next_display(input logic cmd, input logic [3:0] key);
    kct_result_t shown;
    int          total;
    logic [3:0]  ones;
    logic [3:0]  tens;
    if (cmd == CMD_KEY) begin
      if (!cd_running && !buzzing) begin
        if (key <= KEY_DIGIT_MAX) begin
          if (!digit_seen) begin
            pend_units = key;
            pend_tens  = BCD_ZERO;
            digit_seen = 1'b1;
          end else begin
            pend_tens  = pend_units;
            pend_units = key;
          end
        end else if (key == KEY_STAR && digit_seen) begin
          total = int'(pend_tens) * 10 + int'(pend_units);
          if (total == 0) begin
            start_buzzer();
          end else begin
            secs_left  = total[6:0];
            cd_running = 1'b1;
            countdowns_started++;
          end
        end
      end
    end else begin
      if (cd_running) begin
        if (secs_left > 0) secs_left = secs_left - 7'd1;
        if (secs_left == 0) start_buzzer();
      end else if (buzzing) begin
        if (buzz_left > 0) buzz_left = buzz_left - 8'd1;
        if (buzz_left == 0) begin
          buzzing    = 1'b0;
          pend_tens  = BCD_ZERO;
          pend_units = BCD_ZERO;
          digit_seen = 1'b0;
          alarms_done++;
        end
      end
    end

    // While counting or buzzing the remaining seconds are shown, otherwise the entry.
    if (cd_running || buzzing) begin
      ones = 4'(secs_left % 7'd10);
      tens = 4'((secs_left / 7'd10) % 7'd10);
    end else begin
      ones = pend_units;
      tens = pend_tens;
    end
    shown.ones_digit    = ones;
    shown.tens_digit    = tens;
    shown.ones_segments = digit_pattern(ones);
    shown.tens_segments = digit_pattern(tens);
    shown.buzzer_on     = buzzing;
    shown.counting      = cd_running;
    shown.entry_active  = !cd_running && !buzzing;
    return shown;
  endfunction

  function automatic string display_text(input kct_result_t r);
    return $sformatf("ones=%0d tens=%0d segs=%h/%h buzzer=%b counting=%b entry=%b",
                     r.ones_digit, r.tens_digit, r.ones_segments, r.tens_segments,
                     r.buzzer_on, r.counting, r.entry_active);
  endfunction

  function automatic void report_error(input string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("ERROR: %s", msg);
  endfunction

  // Offers one item after a random gap and records its predicted display on transfer.
  task automatic send_item(input logic cmd, input logic [3:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.key_code <= key;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    display_expect_q.push_back(timer_next_display(cmd, key));
    items_sent++;
  endtask

  // Stops offering items and waits until every predicted display has arrived.
  task automatic wait_for_displays();
    in_ch.valid <= 1'b0;
    while (display_expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_alarm_length(input logic [7:0] len);
    wait_for_displays();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= len;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    buzz_len = len;
  endtask

  // Ticks the timer back to entry mode, with the odd ignored key in between.
  task automatic run_down_timer();
    logic [3:0] key;
    while (cd_running || buzzing) begin
      key = 4'($urandom_range(15));
      if ($urandom_range(9) == 0) send_item(CMD_KEY, key);
      else send_item(CMD_TICK, key);
    end
  endtask

  // Keys that do nothing in entry mode, and a tick in entry mode.
  task automatic test_ignored_keys();
    send_item(CMD_TICK, KEY_LETTER_D);
    send_item(CMD_KEY, KEY_STAR);
    send_item(CMD_KEY, KEY_HASH);
    send_item(CMD_KEY, KEY_LETTER_A);
    send_item(CMD_KEY, KEY_LETTER_D);
  endtask

  // A star on 00 starts the alarm at once; keys during the alarm are ignored.
  task automatic test_zero_start();
    send_item(CMD_KEY, BCD_ZERO);
    send_item(CMD_KEY, KEY_STAR);
    send_item(CMD_KEY, 4'd5);
    send_item(CMD_TICK, KEY_LETTER_D);
    send_item(CMD_TICK, BCD_ZERO);
  endtask

  // A short countdown runs into the alarm, which then clears the entry.
  task automatic test_short_countdown();
    send_item(CMD_KEY, BCD_ZERO);
    send_item(CMD_KEY, 4'd2);
    send_item(CMD_KEY, KEY_STAR);
    repeat (4) send_item(CMD_TICK, BCD_ZERO);
  endtask

  // Three digits shift through to 99, which counts all the way down.
  task automatic test_full_countdown();
    send_item(CMD_KEY, 4'd1);
    send_item(CMD_KEY, BCD_NINE);
    send_item(CMD_KEY, BCD_NINE);
    send_item(CMD_KEY, KEY_STAR);
    send_item(CMD_KEY, 4'd4);
    send_item(CMD_KEY, KEY_STAR);
    while (cd_running || buzzing) send_item(CMD_TICK, KEY_LETTER_D);
  endtask

  // The receiver holds off long enough to stall the input; then the sender pauses.
  task automatic test_backpressure();
    stall_hold = 60;
    send_item(CMD_KEY, 4'd8);
    send_item(CMD_KEY, 4'd3);
    send_item(CMD_KEY, KEY_HASH);
    send_item(CMD_KEY, KEY_STAR);
    repeat (6) send_item(CMD_TICK, KEY_STAR);
    wait_for_displays();
    run_down_timer();
  endtask

  // Shortest and longest alarm lengths.
  task automatic test_alarm_length_extremes();
    set_alarm_length(ALARM_LEN_MIN);
    send_item(CMD_KEY, 4'd1);
    send_item(CMD_KEY, KEY_STAR);
    send_item(CMD_TICK, BCD_ZERO);
    send_item(CMD_TICK, BCD_ZERO);
    set_alarm_length(ALARM_LEN_MAX);
    send_item(CMD_KEY, BCD_ZERO);
    send_item(CMD_KEY, KEY_STAR);
    while (buzzing) send_item(CMD_TICK, 4'($urandom_range(15)));
  endtask

  // Mostly well-formed entries with random digits, mixed with noise and broken entries.
  task automatic random_timer_session();
    int         n;
    logic [3:0] d;
    logic       cmd;
    if ($urandom_range(9) < 2) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        cmd = 1'($urandom_range(1));
        d   = 4'($urandom_range(15));
        send_item(cmd, d);
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        // Small tens digits keep most countdowns short.
        if (i == n - 2 && $urandom_range(3) != 0) d = 4'($urandom_range(1));
        else d = 4'($urandom_range(9));
        send_item(CMD_KEY, d);
        if ($urandom_range(9) == 0) begin
          d = 4'($urandom_range(KEY_HASH, KEY_LETTER_D));
          send_item(CMD_KEY, d);
        end
      end
      if ($urandom_range(9) == 0) begin
        d = 4'($urandom_range(15));
        send_item(CMD_TICK, d);
      end
      send_item(CMD_KEY, KEY_STAR);
    end
    run_down_timer();
  endtask

  task automatic test_random_sessions(input int idle_pct, input int stall_pct,
                                      input logic [7:0] len, input int count);
    int target;
    set_alarm_length(len);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + count;
    while (items_sent < target) random_timer_session();
    wait_for_displays();
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, and a counted hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        out_ch.ready <= 1'b0;
        stall_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Each display transfer is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    kct_result_t got;
    kct_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.ones_digit    = out_ch.ones_digit;
      got.tens_digit    = out_ch.tens_digit;
      got.ones_segments = out_ch.ones_segments;
      got.tens_segments = out_ch.tens_segments;
      got.buzzer_on     = out_ch.buzzer_on;
      got.counting      = out_ch.counting;
      got.entry_active  = out_ch.entry_active;
      if (display_expect_q.size() == 0) begin
        report_error($sformatf("unexpected display %s", display_text(got)));
      end else begin
        want = display_expect_q.pop_front();
        displays_checked++;
        if (got.ones_digit !== want.ones_digit || got.tens_digit !== want.tens_digit ||
            got.ones_segments !== want.ones_segments ||
            got.tens_segments !== want.tens_segments ||
            got.buzzer_on !== want.buzzer_on || got.counting !== want.counting ||
            got.entry_active !== want.entry_active) begin
          report_error($sformatf("display %0d: expected %s, got %s", displays_checked,
                                 display_text(want), display_text(got)));
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d displays outstanding.", cycle_count,
             display_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Test sequence.
  initial begin
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    stall_hold         = 0;
    items_sent         = 0;
    displays_checked   = 0;
    error_count        = 0;
    countdowns_started = 0;
    alarms_done        = 0;
    predict_reset();
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_KEY;
    in_ch.key_code <= BCD_ZERO;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ignored_keys();
    test_zero_start();
    test_short_countdown();
    test_full_countdown();
    test_backpressure();
    test_alarm_length_extremes();
    test_random_sessions(0, 0, 8'd3, 40);
    test_random_sessions(84, 0, ALARM_LEN_MIN, 40);
    test_random_sessions(0, 84, 8'($urandom_range(1, 6)), 40);
    test_random_sessions(21, 21, ALARM_LEN_RESET, 40);

    wait_for_displays();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (display_expect_q.size() != 0)
      report_error($sformatf("%0d displays never arrived", display_expect_q.size()));
    $display("Sent %0d keys and ticks, checked %0d displays, %0d mismatches.",
             items_sent, displays_checked, error_count);
    $display("Covered %0d countdowns and %0d completed alarms, alarm lengths 1 to 255.",
             countdowns_started, alarms_done);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
